### hw/rtl/dhfk_pkg.sv
// shared types, constants and rounding helpers of the five-joint forward kinematics core
package dhfk_pkg;

   localparam int ANGLE_W = 16;
   localparam int LEN_W   = 10;
   localparam int ROT_W   = 16;
   localparam int POS_W   = 13;
   localparam int FRAC    = 20;
   localparam int TRIG_W  = 22;   // q.20 sine or cosine, magnitude up to about 1
   localparam int ENT_W   = 24;   // q.20 chained rotation entry
   localparam int TR_W    = 36;   // translation in 2^-20 mm
   localparam int CX_W    = 34;   // cordic x/y, q2.30 plus headroom
   localparam int CZ_W    = 34;
   localparam int ATAN_N  = 24;
   localparam int NUM_JOINTS = 5;

   localparam logic [1:0] CSR_BASE_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_UPPER_ARM   = 2'd1;
   localparam logic [1:0] CSR_FOREARM     = 2'd2;
   localparam logic [1:0] CSR_HAND_OFFSET = 2'd3;

   localparam logic [CX_W-1:0] CORDIC_X0 = CX_W'(34'h026DD3B6A);

   typedef logic signed [CX_W-1:0]   cordic_word_type;
   typedef logic signed [CZ_W-1:0]   cordic_angle_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ENT_W-1:0]  ent_type;
   typedef logic signed [TR_W-1:0]   tr_type;

   typedef struct packed {
      ent_type [2:0][2:0] r;
      tr_type  [2:0]      t;
   } frame_type;

   typedef struct packed {
      logic [LEN_W-1:0] d1;
      logic [LEN_W-1:0] a2;
      logic [LEN_W-1:0] a3;
      logic [LEN_W-1:0] d5;
   } link_cfg_type;

   function automatic cordic_angle_type atan_entry(input int idx);
      logic [31:0] t;
      unique case (idx)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
         15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
         18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
         21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return CZ_W'(t);
   endfunction

   // round half away from zero, shift by 20, 64-bit signed input
   function automatic logic signed [63:0] round_q20(input logic signed [63:0] v);
      logic signed [63:0] mag;
      mag = v[63] ? -v : v;
      mag = (mag + 64'sd524288) >>> FRAC;
      return v[63] ? -mag : mag;
   endfunction

   function automatic logic signed [63:0] round_sh(input logic signed [63:0] v,
                                                   input int s);
      logic signed [63:0] mag;
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      mag  = v[63] ? -v : v;
      mag  = (mag + half) >>> s;
      return v[63] ? -mag : mag;
   endfunction

endpackage

### hw/rtl/dh_forward_kinematics_5dof_core.sv
// top level: five cordic lanes, link frame build, chained matrix stages, output rounding
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | five 16-bit joint angles
//  rsp     | out | rsp_tvalid/tready   | 3x3 rotation q2.14, xyz position mm
//  csr     | in  | csr_valid/ready     | 2-bit register index, 10-bit value
// one request per cycle is accepted while the pipe advances
// the whole pipe advances while the output register is empty or being taken
// a stalled response freezes every stage, so nothing is lost or repeated
// reset clears the valid bits and loads the link lengths with their defaults
module dh_forward_kinematics_5dof_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // joint1..joint5 angles, 16 bits each
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [183:0] rsp_tdata, // rot_r0c0..rot_r2c2 16 b, pos_x/y/z 13 b, 1 b pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import dhfk_pkg::*;

   localparam int RUN   = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
   localparam int DEPTH = RUN + 12;

   link_cfg_type cfg_ff;
   logic [DEPTH-1:0] vld_ff;
   logic en;
   trig_type c [NUM_JOINTS];
   trig_type s [NUM_JOINTS];
   frame_type t_ff [NUM_JOINTS];
   frame_type t_in [NUM_JOINTS];
   frame_type m12, m123, m1234, m12345;
   frame_type d3_ff [2];
   frame_type d4_ff [4];
   frame_type d5_ff [6];
   logic [183:0] out_in, out_ff;
   localparam ent_type ONE = ENT_W'(1 << FRAC);

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{d1: 10'd70, a2: 10'd120, a3: 10'd105, d5: 10'd40};
         vld_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BASE_HEIGHT: cfg_ff.d1 <= csr_data;
               CSR_UPPER_ARM:   cfg_ff.a2 <= csr_data;
               CSR_FOREARM:     cfg_ff.a3 <= csr_data;
               default:         cfg_ff.d5 <= csr_data;
            endcase
         end
         if (en) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // the quarter-turn offsets of shoulder and wrist pitch are folded into the link frames
   for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
      dhfk_cordic_lane #(.STAGES(CORDIC_STAGES)) u_lane (
         .clock(clock), .en(en), .angle(req_tdata[16*j +: 16]),
         .cos_q(c[j]), .sin_q(s[j]));
   end

   always_comb begin
      for (int j = 0; j < NUM_JOINTS; j++) t_in[j] = '0;
      t_in[0].r[0][0] = ENT_W'(c[0]);  t_in[0].r[0][2] = -ENT_W'(s[0]);
      t_in[0].r[1][0] = ENT_W'(s[0]);  t_in[0].r[1][2] = ENT_W'(c[0]);
      t_in[0].r[2][1] = -ONE;
      t_in[0].t[2]    = TR_W'({cfg_ff.d1, 20'h0});
      t_in[1].r[0][0] = ENT_W'(s[1]);  t_in[1].r[0][1] = ENT_W'(c[1]);
      t_in[1].r[1][0] = -ENT_W'(c[1]); t_in[1].r[1][1] = ENT_W'(s[1]);
      t_in[1].r[2][2] = ONE;
      t_in[1].t[0]    = TR_W'($signed({1'b0, cfg_ff.a2}) * s[1]);
      t_in[1].t[1]    = -TR_W'($signed({1'b0, cfg_ff.a2}) * c[1]);
      t_in[2].r[0][0] = ENT_W'(c[2]);  t_in[2].r[0][1] = -ENT_W'(s[2]);
      t_in[2].r[1][0] = ENT_W'(s[2]);  t_in[2].r[1][1] = ENT_W'(c[2]);
      t_in[2].r[2][2] = ONE;
      t_in[2].t[0]    = TR_W'($signed({1'b0, cfg_ff.a3}) * c[2]);
      t_in[2].t[1]    = TR_W'($signed({1'b0, cfg_ff.a3}) * s[2]);
      t_in[3].r[0][0] = ENT_W'(s[3]);  t_in[3].r[0][2] = ENT_W'(c[3]);
      t_in[3].r[1][0] = -ENT_W'(c[3]); t_in[3].r[1][2] = ENT_W'(s[3]);
      t_in[3].r[2][1] = -ONE;
      t_in[4].r[0][0] = ENT_W'(c[4]);  t_in[4].r[0][1] = -ENT_W'(s[4]);
      t_in[4].r[1][0] = ENT_W'(s[4]);  t_in[4].r[1][1] = ENT_W'(c[4]);
      t_in[4].r[2][2] = ONE;
      t_in[4].t[2]    = TR_W'({cfg_ff.d5, 20'h0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NUM_JOINTS; j++) t_ff[j] <= t_in[j];
         d3_ff[0] <= t_ff[2];
         for (int k = 1; k < 2; k++) d3_ff[k] <= d3_ff[k-1];
         d4_ff[0] <= t_ff[3];
         for (int k = 1; k < 4; k++) d4_ff[k] <= d4_ff[k-1];
         d5_ff[0] <= t_ff[4];
         for (int k = 1; k < 6; k++) d5_ff[k] <= d5_ff[k-1];
         out_ff <= out_in;
      end
   end

   // merge: each stage registers its products, then its rounded sums; later link frames are delayed to match
   dhfk_chain_stage u_c1 (.clock(clock), .en(en), .a(t_ff[0]), .b(t_ff[1]), .r(m12));
   dhfk_chain_stage u_c2 (.clock(clock), .en(en), .a(m12), .b(d3_ff[1]), .r(m123));
   dhfk_chain_stage u_c3 (.clock(clock), .en(en), .a(m123), .b(d4_ff[3]), .r(m1234));
   dhfk_chain_stage u_c4 (.clock(clock), .en(en), .a(m1234), .b(d5_ff[5]), .r(m12345));

   always_comb begin
      logic signed [63:0] v;
      out_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            v = round_sh(64'(m12345.r[i][j]), FRAC - 14);
            if (v > 64'sd16384) v = 64'sd16384;
            else if (v < -64'sd16384) v = -64'sd16384;
            out_in[16*(3*i+j) +: 16] = v[15:0];
         end
      end
      for (int i = 0; i < 3; i++) begin
         v = round_q20(64'(m12345.t[i]));
         if (v > 64'sd4095) v = 64'sd4095;
         else if (v < -64'sd4096) v = -64'sd4096;
         out_in[144 + 13*i +: 13] = v[12:0];
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready out of step with output register");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[183] == 1'b0)
      else $error("response pad bit set");
endmodule

### hw/rtl/dhfk_cordic_lane.sv
// pipelined cordic lane: one joint angle to q.20 cosine and sine
module dhfk_cordic_lane #(
   parameter int STAGES = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [dhfk_pkg::ANGLE_W-1:0] angle,
   output dhfk_pkg::trig_type          cos_q,
   output dhfk_pkg::trig_type          sin_q
);
   import dhfk_pkg::*;

   localparam int RUN = (STAGES < ATAN_N) ? STAGES : ATAN_N;

   cordic_word_type  x_ff [RUN+1];
   cordic_word_type  y_ff [RUN+1];
   cordic_angle_type z_ff [RUN+1];
   logic [1:0]       q_ff [RUN+1];
   trig_type         cos_ff, sin_ff;
   cordic_word_type  x_in [RUN+1];
   cordic_word_type  y_in [RUN+1];
   cordic_angle_type z_in [RUN+1];
   trig_type         cos_in, sin_in;
   trig_type         c_r, s_r;

   assign x_in[0] = CORDIC_X0;
   assign y_in[0] = '0;
   assign z_in[0] = cordic_angle_type'({angle[13:0], 16'h0});

   for (genvar i = 0; i < RUN; i++) begin : g_stage
      always_comb begin
         if (!z_ff[i][CZ_W-1]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_entry(i);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_entry(i);
         end
      end
   end

   always_comb begin
      c_r = TRIG_W'(round_sh(64'(x_ff[RUN]), 30 - FRAC));
      s_r = TRIG_W'(round_sh(64'(y_ff[RUN]), 30 - FRAC));
      unique case (q_ff[RUN])
         2'd0: begin cos_in = c_r;  sin_in = s_r;  end
         2'd1: begin cos_in = -s_r; sin_in = c_r;  end
         2'd2: begin cos_in = -c_r; sin_in = -s_r; end
         default: begin cos_in = s_r; sin_in = -c_r; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x_in[0];
         y_ff[0] <= y_in[0];
         z_ff[0] <= z_in[0];
         q_ff[0] <= angle[15:14];
         for (int i = 0; i < RUN; i++) begin
            x_ff[i+1] <= x_in[i+1];
            y_ff[i+1] <= y_in[i+1];
            z_ff[i+1] <= z_in[i+1];
            q_ff[i+1] <= q_ff[i];
         end
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;
endmodule

### hw/rtl/dhfk_chain_stage.sv
// one registered link multiply: frame a times frame b, translation of a added
module dhfk_chain_stage (
   input  logic                clock,
   input  logic                en,
   input  dhfk_pkg::frame_type a,
   input  dhfk_pkg::frame_type b,
   output dhfk_pkg::frame_type r
);
   import dhfk_pkg::*;

   // products registered, then summed and rounded
   logic signed [59:0] pr_ff [3][3][3];
   logic signed [59:0] pt_ff [3][3];
   tr_type             at_ff [3];
   frame_type          r_ff, r_in;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            at_ff[i] <= a.t[i];
            for (int j = 0; j < 3; j++) begin
               for (int k = 0; k < 3; k++)
                  pr_ff[i][j][k] <= 60'(a.r[i][k]) * 60'(b.r[k][j]);
               pt_ff[i][j] <= 60'(a.r[i][j]) * 60'(b.t[j]);
            end
         end
         r_ff <= r_in;
      end
   end

   always_comb begin
      r_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++)
            r_in.r[i][j] = ENT_W'(round_q20(64'(pr_ff[i][j][0]) + 64'(pr_ff[i][j][1])
                                            + 64'(pr_ff[i][j][2])));
         r_in.t[i] = TR_W'(round_q20(64'(pt_ff[i][0]) + 64'(pt_ff[i][1])
                                     + 64'(pt_ff[i][2])) + 64'(at_ff[i]));
      end
   end

   assign r = r_ff;
endmodule

### sim/testbench.sv
// self-checking testbench of the five-joint forward kinematics core
`timescale 1ns / 100ps

module testbench;
   import dhfk_pkg::*;

   localparam int STAGES = 16;

   typedef longint frame_mat [0:2][0:3];

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_BASE_HEIGHT;
   logic [9:0]   csr_data = '0;

   logic [79:0]  pending_angles[$];
   logic [183:0] expected_poses[$];
   logic [9:0]   link_len [0:3];
   int           fail_count = 0;
   int           req_gap = 0;
   int           rsp_gap = 0;
   bit           quiet = 1'b0;

   const longint atan_tab [0:23] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   dh_forward_kinematics_5dof_core #(.CORDIC_STAGES(STAGES)) DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint round_away(longint v, int s);
      longint half;
      half = longint'(1) <<< (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -(((-v) + half) >>> s);
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // cos and sin of one angle code, q.20
   task automatic joint_trig(input logic [15:0] code, output longint cq, output longint sq);
      longint x, y, z, dx, dy, c, s;
      x = 64'h26DD3B6A;
      y = 0;
      z = longint'(code[13:0]) * 65536;
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      c = round_away(x, 10);
      s = round_away(y, 10);
      case (code[15:14])
         2'd0: begin cq = c;  sq = s;  end
         2'd1: begin cq = -s; sq = c;  end
         2'd2: begin cq = -c; sq = -s; end
         default: begin cq = s; sq = -c; end
      endcase
   endtask

   task automatic predict_pose(input logic [79:0] angles, output logic [183:0] pose);
      longint  c [0:4];
      longint  s [0:4];
      longint  one, d1, a2, a3, d5, sum, v;
      frame_mat links [0:4];
      frame_mat acc, tmp;
      one = longint'(1) <<< 20;
      d1 = link_len[0]; a2 = link_len[1]; a3 = link_len[2]; d5 = link_len[3];
      for (int n = 0; n < 5; n++) joint_trig(angles[16*n +: 16], c[n], s[n]);
      links[0] = '{'{c[0], 0, -s[0], 0}, '{s[0], 0, c[0], 0}, '{0, -one, 0, d1 * one}};
      links[1] = '{'{s[1], c[1], 0, a2 * s[1]}, '{-c[1], s[1], 0, -(a2 * c[1])},
                   '{0, 0, one, 0}};
      links[2] = '{'{c[2], -s[2], 0, a3 * c[2]}, '{s[2], c[2], 0, a3 * s[2]},
                   '{0, 0, one, 0}};
      links[3] = '{'{s[3], 0, c[3], 0}, '{-c[3], 0, s[3], 0}, '{0, -one, 0, 0}};
      links[4] = '{'{c[4], -s[4], 0, 0}, '{s[4], c[4], 0, 0}, '{0, 0, one, d5 * one}};
      acc = links[0];
      for (int n = 1; n < 5; n++) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++) begin
               sum = 0;
               for (int k = 0; k < 3; k++) sum += acc[i][k] * links[n][k][j];
               tmp[i][j] = round_away(sum, 20);
               if (j == 3) tmp[i][j] += acc[i][3];
            end
         acc = tmp;
      end
      pose = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            v = sat(round_away(acc[i][j], 6), -16384, 16384);
            pose[16*(3*i+j) +: 16] = v[15:0];
         end
         v = sat(round_away(acc[i][3], 20), -4096, 4095);
         pose[144 + 13*i +: 13] = v[12:0];
      end
   endtask

   // request driver
   always @(posedge clock) begin
      logic [183:0] pose;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pose(req_tdata, pose);
            expected_poses.push_back(pose);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else if (pending_angles.size() > 0) begin
               req_tdata <= pending_angles.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and register shadow
   always @(posedge clock) begin
      logic [183:0] want;
      int off, w;
      string names [0:11];
      names = '{"rot_r0c0", "rot_r0c1", "rot_r0c2", "rot_r1c0", "rot_r1c1", "rot_r1c2",
                "rot_r2c0", "rot_r2c1", "rot_r2c2", "pos_x", "pos_y", "pos_z"};
      if (reset) begin
         rsp_tready <= 1'b0;
         link_len <= '{10'd70, 10'd120, 10'd105, 10'd40};
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_HEIGHT: link_len[0] <= csr_data;
               CSR_UPPER_ARM:   link_len[1] <= csr_data;
               CSR_FOREARM:     link_len[2] <= csr_data;
               CSR_HAND_OFFSET: link_len[3] <= csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_poses.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_poses.pop_front();
               for (int f = 0; f < 12; f++) begin
                  off = f < 9 ? 16 * f : 144 + 13 * (f - 9);
                  w = f < 9 ? 16 : 13;
                  if (((want ^ rsp_tdata) >> off) & ((184'd1 << w) - 1)) begin
                     $error("%s expected %0h actual %0h", names[f],
                            (want >> off) & ((184'd1 << w) - 1),
                            (rsp_tdata >> off) & ((184'd1 << w) - 1));
                     fail_count++;
                  end
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_link(input logic [1:0] idx, input logic [9:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      do @(posedge clock);
      while (pending_angles.size() > 0 || req_tvalid || expected_poses.size() > 0);
   endtask

   function automatic logic [15:0] pick_angle();
      logic [15:0] edges [0:7];
      edges = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000,
                16'hFFFF};
      if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [79:0] random_angles();
      logic [79:0] a;
      for (int n = 0; n < 5; n++) a[16*n +: 16] = pick_angle();
      return a;
   endfunction

   initial begin
      logic [15:0] corner [0:7];
      corner = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000,
                 16'hFFFF};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // reset lengths, each angle corner on all joints, then each joint alone, then random angles
      for (int k = 0; k < 8; k++) pending_angles.push_back({5{corner[k]}});
      for (int n = 0; n < 5; n++) begin
         pending_angles.push_back(80'h0 | (80'h4000 << (16 * n)));
         pending_angles.push_back(80'h0 | (80'hC000 << (16 * n)));
      end
      for (int k = 0; k < 4; k++) pending_angles.push_back(random_angles());
      drain();
      for (int p = 0; p < 6; p++) begin
         for (int r = 0; r < 4; r++)
            write_link(r[1:0], p == 0 ? 10'h3FF : (p == 1 ? 10'h000 : 10'($urandom)));
         if (p == 5) quiet = 1'b1;
         for (int k = 0; k < (p < 2 ? 150 : 425); k++) pending_angles.push_back(random_angles());
         drain();
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
